// File: hdl/c2sp_pkg.sv
// ----------------------------------------------------------------------------
// c2sp_pkg
// Shared types and constants of the strided, padded 3x3 convolution stream.
// ----------------------------------------------------------------------------
package c2sp_pkg;

    // axis arithmetic width, covers sizes up to 4096 plus border and stride
    localparam int AXW = 14;
    localparam int PIX_W = 16;
    localparam int IDX_W = 10;
    localparam int PROD_W = 32;
    localparam int ACC_W = 36;
    localparam int COEFF_W = 48;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;
    localparam int OUT_TDATA_W = 56;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_COEFF_TOP    = 3'd0,
        REG_COEFF_MID    = 3'd1,
        REG_COEFF_BOT    = 3'd2,
        REG_IMAGE_WIDTH  = 3'd3,
        REG_IMAGE_HEIGHT = 3'd4,
        REG_STEP_SIZE    = 3'd5,
        REG_BORDER_ZEROS = 3'd6
    } cfg_index_t;

    // effective settings seen by front and back
    typedef struct packed {
        logic [2:0][COEFF_W-1:0] coeff;     // [0] top row, column 0 in low bits
        logic [AXW-1:0]          width_n;   // clamped width
        logic [AXW-1:0]          height_n;  // clamped height
        logic [1:0]              stride;    // never zero
        logic                    pad;
    } cfg_t;

    // up to two placements along one axis completed by a pixel
    typedef struct packed {
        logic                        two;   // second placement present
        logic [1:0][IDX_W-1:0]       idx;   // output index
        logic [1:0]                  last;  // index is the last one of the axis
        logic [1:0][2:0]             dsh;   // window offset of kernel tap 0
        logic [1:0][2:0]             mask;  // kernel taps that see real pixels
    } axis_t;

    // one queued job: window snapshot plus placements
    typedef struct packed {
        logic [2:0][2:0][PIX_W-1:0] win;   // [row][col], row 2 and col 2 newest
        axis_t                      row;
        axis_t                      col;
    } job_t;

endpackage

// File: hdl/c2sp_front.sv
// ----------------------------------------------------------------------------
// c2sp_front
// Accepts pixels, keeps line stores, window and counters, and classifies
// which kernel placements each pixel completes.
// ----------------------------------------------------------------------------
module c2sp_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  c2sp_pkg::cfg_t                 cfg,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [c2sp_pkg::PIX_W-1:0]     s_tdata,
    input  logic [c2sp_pkg::QCNT_W-1:0]    q_count,
    output logic                           push,
    output c2sp_pkg::job_t                 job
);

    localparam int AXW = c2sp_pkg::AXW;
    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    typedef struct packed {
        logic [1:0]     cnt;
        logic [AXW-1:0] o0;
        logic           last0;
        logic           last1;
    } axis_a_t;

    // divide by a stride of 1, 2 or 3
    function automatic logic [AXW-1:0] div_s(input logic [AXW-1:0] x, input logic [1:0] s);
        logic [31:0] p;
        p = 32'(x) * 32'd43691;
        case (s)
            2'd2:    div_s = x >> 1;
            2'd3:    div_s = AXW'(p >> 17);
            default: div_s = x;
        endcase
    endfunction

    function automatic logic [AXW-1:0] mul_s(input logic [AXW-1:0] q, input logic [1:0] s);
        case (s)
            2'd2:    mul_s = AXW'(q << 1);
            2'd3:    mul_s = AXW'(q + (q << 1));
            default: mul_s = q;
        endcase
    endfunction

    // placements along one axis that complete at this index
    function automatic axis_a_t classify(input logic [AXW-1:0] idx, input logic [AXW-1:0] n,
                                         input logic pad, input logic [1:0] s);
        axis_a_t        res;
        logic [AXW-1:0] padw;
        logic [AXW-1:0] nout;
        logic [AXW-1:0] t;
        logic [AXW-1:0] q;
        logic [AXW-1:0] o;
        res  = '0;
        padw = AXW'(pad);
        nout = AXW'(div_s(AXW'(n + (padw << 1) - AXW'(3)), s) + AXW'(1));
        if (AXW'(idx + AXW'(1)) < n) begin
            if (AXW'(idx + padw) >= AXW'(2)) begin
                t = AXW'(idx + padw - AXW'(2));
                q = div_s(t, s);
                if (mul_s(q, s) == t && q < nout) begin
                    res.cnt = 2'd1;
                    res.o0  = q;
                end
            end
        end else if (AXW'(idx + AXW'(1)) == n) begin
            o = div_s(AXW'(n - AXW'(3) + padw + AXW'(s) - AXW'(1)), s);
            res.o0 = o;
            if (o < nout) begin
                res.cnt = (AXW'(o + AXW'(1)) < nout) ? 2'd2 : 2'd1;
            end
        end
        res.last0 = (res.o0 == AXW'(nout - AXW'(1)));
        res.last1 = (AXW'(res.o0 + AXW'(1)) == AXW'(nout - AXW'(1)));
        return res;
    endfunction

    // window offsets and tap masks of the placements
    function automatic c2sp_pkg::axis_t build_axis(input axis_a_t a,
                                                   input logic [AXW-1:0] idx,
                                                   input logic [AXW-1:0] n,
                                                   input logic pad, input logic [1:0] s);
        c2sp_pkg::axis_t         res;
        logic [AXW-1:0]          o;
        logic signed [AXW+1:0]   base;
        logic signed [AXW+1:0]   dd;
        logic signed [AXW+1:0]   pos;
        logic signed [AXW+1:0]   wp;
        res = '0;
        res.two = (a.cnt == 2'd2);
        for (int k = 0; k < 2; k++) begin
            o    = AXW'(a.o0 + AXW'(k));
            base = $signed({2'b00, mul_s(o, s)}) - $signed({{(AXW + 1){1'b0}}, pad});
            dd   = base - $signed({2'b00, idx}) + $signed((AXW + 2)'(2));
            res.idx[k]  = o[c2sp_pkg::IDX_W-1:0];
            res.last[k] = (k == 0) ? a.last0 : a.last1;
            res.dsh[k]  = dd[2:0];
            for (int kk = 0; kk < 3; kk++) begin
                pos = base + $signed((AXW + 2)'(kk));
                wp  = dd + $signed((AXW + 2)'(kk));
                res.mask[k][kk] = (pos >= 0) && (pos < $signed({2'b00, n}))
                                  && (wp >= 0) && (wp <= 2);
            end
        end
        return res;
    endfunction

    logic [c2sp_pkg::PIX_W-1:0] mem_top [MAX_WIDTH];
    logic [c2sp_pkg::PIX_W-1:0] mem_mid [MAX_WIDTH];

    logic [CW-1:0] col_cnt_reg;
    logic [RW-1:0] row_cnt_reg;

    logic                         valid_a_reg;
    logic [c2sp_pkg::PIX_W-1:0]   pix_a_reg;
    logic [c2sp_pkg::PIX_W-1:0]   above2_a_reg;
    logic [c2sp_pkg::PIX_W-1:0]   above1_a_reg;
    logic [CW-1:0]                col_a_reg;
    logic [RW-1:0]                row_a_reg;

    logic [2:0][2:0][c2sp_pkg::PIX_W-1:0] win_reg;

    logic           valid_b_reg;
    axis_a_t        rax_b_reg;
    axis_a_t        cax_b_reg;
    logic [AXW-1:0] row_b_reg;
    logic [AXW-1:0] col_b_reg;

    logic                     accept;
    logic [c2sp_pkg::QCNT_W:0] used;
    axis_a_t                  rax_a;
    axis_a_t                  cax_a;

    // credit check: queue slots held for every word still in flight
    assign used = {1'b0, q_count} + {c2sp_pkg::QCNT_W'(0), valid_a_reg}
                  + {c2sp_pkg::QCNT_W'(0), valid_b_reg};
    assign s_tready = (used < (c2sp_pkg::QCNT_W + 1)'(c2sp_pkg::QUEUE_DEPTH));
    assign accept   = s_tvalid && s_tready;

    // raster counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (accept) begin
            if (AXW'(col_cnt_reg) + AXW'(1) >= cfg.width_n) begin
                col_cnt_reg <= '0;
                if (AXW'(row_cnt_reg) + AXW'(1) >= cfg.height_n) begin
                    row_cnt_reg <= '0;
                end else begin
                    row_cnt_reg <= RW'(row_cnt_reg + 1'b1);
                end
            end else begin
                col_cnt_reg <= CW'(col_cnt_reg + 1'b1);
            end
        end
    end

    // line stores: read on accept, written back in the cycle after
    always_ff @(posedge aclk) begin
        if (accept) begin
            above2_a_reg <= mem_top[col_cnt_reg];
            above1_a_reg <= mem_mid[col_cnt_reg];
        end
        if (valid_a_reg) begin
            mem_top[col_a_reg] <= above1_a_reg;
            mem_mid[col_a_reg] <= pix_a_reg;
        end
    end

    // stage a capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
        end else begin
            valid_a_reg <= accept;
        end
        if (accept) begin
            pix_a_reg <= s_tdata;
            col_a_reg <= col_cnt_reg;
            row_a_reg <= row_cnt_reg;
        end
    end

    assign rax_a = classify(AXW'(row_a_reg), cfg.height_n, cfg.pad, cfg.stride);
    assign cax_a = classify(AXW'(col_a_reg), cfg.width_n, cfg.pad, cfg.stride);

    // window shift and stage b capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= '0;
            valid_b_reg <= 1'b0;
        end else begin
            valid_b_reg <= valid_a_reg;
            if (valid_a_reg) begin
                for (int i = 0; i < 3; i++) begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= above2_a_reg;
                win_reg[1][2] <= above1_a_reg;
                win_reg[2][2] <= pix_a_reg;
            end
        end
        if (valid_a_reg) begin
            rax_b_reg <= rax_a;
            cax_b_reg <= cax_a;
            row_b_reg <= AXW'(row_a_reg);
            col_b_reg <= AXW'(col_a_reg);
        end
    end

    // job build, only pixels that complete a placement enter the queue
    assign job.win = win_reg;
    assign job.row = build_axis(rax_b_reg, row_b_reg, cfg.height_n, cfg.pad, cfg.stride);
    assign job.col = build_axis(cax_b_reg, col_b_reg, cfg.width_n, cfg.pad, cfg.stride);
    assign push    = valid_b_reg && (rax_b_reg.cnt != 2'd0) && (cax_b_reg.cnt != 2'd0);

endmodule

// File: hdl/c2sp_queue.sv
// ----------------------------------------------------------------------------
// c2sp_queue
// Short job queue between the classifying front and the computing back.
// ----------------------------------------------------------------------------
module c2sp_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  c2sp_pkg::job_t                push_job,
    input  logic                          pop,
    output c2sp_pkg::job_t                head,
    output logic                          not_empty,
    output logic [c2sp_pkg::QCNT_W-1:0]   count
);

    c2sp_pkg::job_t                entries [c2sp_pkg::QUEUE_DEPTH];
    logic [c2sp_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [c2sp_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [c2sp_pkg::QCNT_W-1:0]   count_reg;

    assign head      = entries[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= c2sp_pkg::QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop) begin
                rd_ptr_reg <= c2sp_pkg::QPTR_W'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop) begin
                count_reg <= c2sp_pkg::QCNT_W'(count_reg + 1'b1);
            end else if (pop && !push) begin
                count_reg <= c2sp_pkg::QCNT_W'(count_reg - 1'b1);
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hdl/c2sp_back.sv
// ----------------------------------------------------------------------------
// c2sp_back
// Walks the placements of each queued job and computes the saturated
// nine-tap sum in a four-stage pipeline ending in the output register.
// ----------------------------------------------------------------------------
module c2sp_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  c2sp_pkg::cfg_t                    cfg,
    input  c2sp_pkg::job_t                    head,
    input  logic                              not_empty,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [c2sp_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);

    localparam int PIX_W  = c2sp_pkg::PIX_W;
    localparam int PROD_W = c2sp_pkg::PROD_W;
    localparam int ACC_W  = c2sp_pkg::ACC_W;
    localparam int IDX_W  = c2sp_pkg::IDX_W;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             run_last;
        logic             frame_last;
    } meta_t;

    logic    adv;
    logic    issue;
    logic    i_reg;
    logic    j_reg;
    logic    run_last_sel;
    meta_t   meta_sel;
    logic [8:0][PIX_W-1:0] pix_sel;

    logic                            v1_reg;
    meta_t                           meta1_reg;
    logic [8:0][PIX_W-1:0]           pix1_reg;
    logic                            v2_reg;
    meta_t                           meta2_reg;
    logic signed [PROD_W-1:0]        prod2_reg [9];
    logic                            v3_reg;
    meta_t                           meta3_reg;
    logic signed [PROD_W:0]          part3_reg [5];
    logic                            out_valid_reg;
    logic [c2sp_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic                            out_last_reg;
    logic                            out_user_reg;

    logic signed [ACC_W-1:0] total;
    logic signed [PROD_W-1:0] sat;

    // whole pipeline moves when the output register can take a word
    assign adv   = !out_valid_reg || m_tready;
    assign issue = adv && not_empty;

    assign run_last_sel = (i_reg == head.row.two) && (j_reg == head.col.two);
    assign pop          = issue && run_last_sel;

    // realign window to the placement and zero taps outside the image
    always_comb begin
        logic [2:0] wy;
        logic [2:0] wx;
        for (int ky = 0; ky < 3; ky++) begin
            for (int kx = 0; kx < 3; kx++) begin
                wy = 3'(head.row.dsh[i_reg] + 3'(ky));
                wx = 3'(head.col.dsh[j_reg] + 3'(kx));
                if (head.row.mask[i_reg][ky] && head.col.mask[j_reg][kx]) begin
                    pix_sel[ky * 3 + kx] = head.win[wy[1:0]][wx[1:0]];
                end else begin
                    pix_sel[ky * 3 + kx] = '0;
                end
            end
        end
        meta_sel.row        = head.row.idx[i_reg];
        meta_sel.col        = head.col.idx[j_reg];
        meta_sel.run_last   = run_last_sel;
        meta_sel.frame_last = head.row.last[i_reg] && head.col.last[j_reg];
    end

    // placement sequencer, output row first then column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg <= 1'b0;
            j_reg <= 1'b0;
        end else if (issue) begin
            if (run_last_sel) begin
                i_reg <= 1'b0;
                j_reg <= 1'b0;
            end else if (!j_reg && head.col.two) begin
                j_reg <= 1'b1;
            end else begin
                j_reg <= 1'b0;
                i_reg <= 1'b1;
            end
        end
    end

    // final sum with saturation to 32 bits
    always_comb begin
        total = ACC_W'(part3_reg[0]) + ACC_W'(part3_reg[1]) + ACC_W'(part3_reg[2])
              + ACC_W'(part3_reg[3]) + ACC_W'(part3_reg[4]);
        if (total > $signed(ACC_W'(36'sh07FFFFFFF))) begin
            sat = 32'sh7FFFFFFF;
        end else if (total < $signed(36'shF80000000)) begin
            sat = 32'sh80000000;
        end else begin
            sat = total[PROD_W-1:0];
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // data path: select, multiply, pair add, final add
    always_ff @(posedge aclk) begin
        if (adv) begin
            pix1_reg  <= pix_sel;
            meta1_reg <= meta_sel;
            for (int k = 0; k < 9; k++) begin
                prod2_reg[k] <= $signed(pix1_reg[k])
                                * $signed(cfg.coeff[k / 3][(k % 3) * PIX_W +: PIX_W]);
            end
            meta2_reg <= meta1_reg;
            for (int k = 0; k < 4; k++) begin
                part3_reg[k] <= (PROD_W + 1)'(prod2_reg[2 * k])
                                + (PROD_W + 1)'(prod2_reg[2 * k + 1]);
            end
            part3_reg[4] <= (PROD_W + 1)'(prod2_reg[8]);
            meta3_reg    <= meta2_reg;
            out_data_reg <= {4'b0000, meta3_reg.col, meta3_reg.row, sat};
            out_last_reg <= meta3_reg.run_last;
            out_user_reg <= meta3_reg.frame_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

// File: hdl/conv2d_stride_pad_stream.sv
// ----------------------------------------------------------------------------
// conv2d_stride_pad_stream
// Streaming 3x3 convolution with stride 1..3 and optional one-pixel zero
// border over signed Q8.8 pixels, giving saturated Q16.16 sums.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one pixel word per cycle while s_tready is high, in
//   raster order. Each finished kernel placement leaves on the m_ channel
//   with its output row and column; m_tlast marks the last result caused
//   by one pixel, m_tuser the final result of the output frame.
//   The cfg channel is always ready and must be written only while idle.
//   Throughput: one pixel per cycle while s_tready is high; the compute
//   pipeline gives one result per cycle unless m_tready stalls it, so a
//   pixel that completes k placements holds the back end for k results,
//   and a four-entry job queue absorbs the difference.
//   Reset clears counters, window and queue; the line stores are not
//   cleared, since unwritten entries only feed taps outside the image.
//   When m_tready is low the result stays in the output register, the
//   queue fills, and s_tready drops once no queue slot is left for the
//   pixels in flight.
// ----------------------------------------------------------------------------
module conv2d_stride_pad_stream #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // cfg write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [2:0]                         cfg_index,
    input  logic [c2sp_pkg::COEFF_W-1:0]       cfg_data,
    // pixel input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [c2sp_pkg::PIX_W-1:0]         s_tdata,   // [15:0] pixel
    // result output
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] conv_value, [41:32] result_row, [51:42] result_col, rest zero
    output logic [c2sp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tlast,   // run_last
    output logic                               m_tuser    // frame_last
);

    localparam int AXW = c2sp_pkg::AXW;

    logic [2:0][c2sp_pkg::COEFF_W-1:0] coeff_reg;
    logic [10:0]                       width_reg;
    logic [10:0]                       height_reg;
    logic [1:0]                        step_reg;
    logic                              border_reg;

    c2sp_pkg::cfg_t                    cfg;
    logic                              push;
    logic                              pop;
    logic                              not_empty;
    logic [c2sp_pkg::QCNT_W-1:0]       q_count;
    c2sp_pkg::job_t                    push_job;
    c2sp_pkg::job_t                    head;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg  <= '0;
            width_reg  <= 11'd1024;
            height_reg <= 11'd1024;
            step_reg   <= 2'd1;
            border_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (c2sp_pkg::cfg_index_t'(cfg_index))
                c2sp_pkg::REG_COEFF_TOP:    coeff_reg[0] <= cfg_data;
                c2sp_pkg::REG_COEFF_MID:    coeff_reg[1] <= cfg_data;
                c2sp_pkg::REG_COEFF_BOT:    coeff_reg[2] <= cfg_data;
                c2sp_pkg::REG_IMAGE_WIDTH:  width_reg    <= cfg_data[10:0];
                c2sp_pkg::REG_IMAGE_HEIGHT: height_reg   <= cfg_data[10:0];
                c2sp_pkg::REG_STEP_SIZE:    step_reg     <= cfg_data[1:0];
                c2sp_pkg::REG_BORDER_ZEROS: border_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective sizes and stride
    always_comb begin
        cfg.coeff = coeff_reg;
        if (width_reg < 11'd3) begin
            cfg.width_n = AXW'(3);
        end else if (AXW'(width_reg) > AXW'(MAX_WIDTH)) begin
            cfg.width_n = AXW'(MAX_WIDTH);
        end else begin
            cfg.width_n = AXW'(width_reg);
        end
        if (height_reg < 11'd3) begin
            cfg.height_n = AXW'(3);
        end else if (AXW'(height_reg) > AXW'(MAX_HEIGHT)) begin
            cfg.height_n = AXW'(MAX_HEIGHT);
        end else begin
            cfg.height_n = AXW'(height_reg);
        end
        cfg.stride = (step_reg == 2'd0) ? 2'd1 : step_reg;
        cfg.pad    = border_reg;
    end

    c2sp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_count  (q_count),
        .push     (push),
        .job      (push_job)
    );

    c2sp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .count     (q_count)
    );

    c2sp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// File: hdl/c2sp_checker.sv
// ----------------------------------------------------------------------------
// c2sp_checker
// Port-level checks of the convolution stream, bound to the top level.
// ----------------------------------------------------------------------------
module c2sp_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [c2sp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic                               m_tlast,
    input logic                               m_tuser
);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tlast) && $stable(m_tuser))
        else $error("result word changed under stall");

    // frame end is always the last result of its pixel
    a_frame_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without run end");

    // reset empties the output
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // reset frees every queue slot
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

endmodule

bind conv2d_stride_pad_stream c2sp_checker u_c2sp_checker (.*);
